FILE: hdl/distance_table_interpolator_defines.svh
// Assertion macros for the files that check their own logic.
`ifndef DISTANCE_TABLE_INTERPOLATOR_DEFINES_SVH
`define DISTANCE_TABLE_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/dti_pkg.sv
package dti_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DW          = 32;
    localparam int SW          = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_STEPS   = 32;
    localparam int DCNT_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY    = 2'd1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [2:0] REGION_BELOW  = 3'd0;
    localparam logic [2:0] REGION_EXACT  = 3'd1;
    localparam logic [2:0] REGION_INTERP = 3'd2;
    localparam logic [2:0] REGION_ABOVE  = 3'd3;
    localparam logic [2:0] REGION_WRITE  = 3'd4;

    localparam logic [2:0] RD_ZERO  = 3'd0;
    localparam logic [2:0] RD_LAST  = 3'd1;
    localparam logic [2:0] RD_PROBE = 3'd2;
    localparam logic [2:0] RD_HI    = 3'd3;
    localparam logic [2:0] RD_LO    = 3'd4;

    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_PEN  = 2'd1;
    localparam logic [1:0] SRC_RDV  = 2'd2;
    localparam logic [1:0] SRC_INT  = 2'd3;

    localparam logic [31:0] PENALTY_RESET = 32'd655360000;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       srch_init;
        logic       srch_upd;
        logic       lat_hi;
        logic       lat_lo;
        logic       mul;
        logic       div_step;
        logic       res_load;
        logic [1:0] res_src;
        logic [2:0] res_region;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic q_lt;
        logic q_gt;
        logic q_eq;
        logic cnt_zero;
        logic i_zero;
        logic den_le0;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/dti_datapath.sv
module dti_datapath import dti_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data,
    input  logic [103:0]         i_in_data,
    input  logic [1:0]           i_in_user,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [95:0]          o_out_data,
    output logic [2:0]           o_out_user
);

    logic [8:0]      r_num;
    logic [DW-1:0]   r_pen;
    logic            r_clr;
    logic [DW-1:0]   r_q;
    logic [2*DW-1:0] r_mem [TABLE_DEPTH];
    logic [2*DW-1:0] r_rdata;
    logic [CNT_W-1:0] r_first, r_count, r_i;
    logic [DW-1:0]   r_dhi, r_vhi, r_vlo, r_den, r_num_op, r_mag, r_lo;
    logic            r_neg;
    logic [DW:0]     r_rem;
    logic [DW-1:0]   r_res_v;
    logic [2:0]      r_res_r;
    logic            r_ovalid;
    logic [DW-1:0]   r_ovalue;
    logic [SW-1:0]   r_oscore;
    logic [2:0]      r_oregion;
    logic [SW-1:0]   r_score;
    logic [SW-1:0]   n_score;

    logic [CNT_W-1:0] w_n, w_step, w_probe, w_i, w_last, w_rd_addr;
    logic [DW-1:0]    w_rd, w_rv, w_in_idx_d, w_in_val, w_in_q, w_sub, w_clamp;
    logic [7:0]       w_in_idx;
    logic [DW:0]      w_diff, w_t, w_interp;
    logic             w_ge;
    logic [2*DW-1:0]  w_prod;

    assign w_in_idx   = i_in_data[7:0];
    assign w_in_idx_d = i_in_data[39:8];
    assign w_in_val   = i_in_data[71:40];
    assign w_in_q     = i_in_data[103:72];
    assign w_rd       = r_rdata[DW-1:0];
    assign w_rv       = r_rdata[2*DW-1:DW];

    always_comb begin
        if (r_num == 9'd0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_num) > TABLE_DEPTH) begin
            w_n = CNT_W'(TABLE_DEPTH);
        end else begin
            w_n = CNT_W'(r_num);
        end
    end

    assign w_last  = w_n - CNT_W'(1);
    assign w_step  = r_count >> 1;
    assign w_probe = r_first + w_step;
    assign w_i     = (r_first >= w_n) ? w_last : r_first;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO:  w_rd_addr = '0;
            RD_LAST:  w_rd_addr = w_last;
            RD_PROBE: w_rd_addr = w_probe;
            RD_HI:    w_rd_addr = w_i;
            RD_LO:    w_rd_addr = r_i - CNT_W'(1);
            default:  w_rd_addr = '0;
        endcase
    end

    assign w_sub   = r_q - w_rd;
    assign w_clamp = (r_q < w_rd) ? '0 : ((w_sub > (r_dhi - w_rd)) ? (r_dhi - w_rd) : w_sub);
    assign w_diff  = {r_vhi[DW-1], r_vhi} - {w_rv[DW-1], w_rv};
    assign w_prod  = r_num_op * r_mag;
    assign w_t     = {r_rem[DW-1:0], r_lo[DW-1]};
    assign w_ge    = w_t >= {1'b0, r_den};
    assign w_interp = r_neg ? ({r_vlo[DW-1], r_vlo} - {1'b0, r_lo})
                            : ({r_vlo[DW-1], r_vlo} + {1'b0, r_lo});

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in_user[0] == FUNC_WRITE) && (32'(w_in_idx) < TABLE_DEPTH)) begin
            r_mem[IDX_W'(w_in_idx)] <= {w_in_val, w_in_idx_d};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 9'd1;
            r_pen <= PENALTY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NUM_POINTS) begin
                r_num <= i_cfg_data[8:0];
            end else if (i_cfg_idx == REG_PENALTY) begin
                r_pen <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_clr <= i_in_user[1];
            r_q   <= w_in_q;
        end
        if (i_cmd.srch_init) begin
            r_first <= '0;
            r_count <= w_n;
        end else if (i_cmd.srch_upd) begin
            if (w_rd < r_q) begin
                r_first <= w_probe + CNT_W'(1);
                r_count <= r_count - w_step - CNT_W'(1);
            end else begin
                r_count <= w_step;
            end
        end
        if (i_cmd.rd_en && i_cmd.rd_sel == RD_HI) begin
            r_i <= w_i;
        end
        if (i_cmd.lat_hi) begin
            r_dhi <= w_rd;
            r_vhi <= w_rv;
        end
        if (i_cmd.lat_lo) begin
            r_vlo    <= w_rv;
            r_den    <= r_dhi - w_rd;
            r_num_op <= w_clamp;
            r_neg    <= w_diff[DW];
            r_mag    <= w_diff[DW] ? DW'(-w_diff) : w_diff[DW-1:0];
        end
        if (i_cmd.mul) begin
            r_rem <= {1'b0, w_prod[2*DW-1:DW]};
            r_lo  <= w_prod[DW-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_t - {1'b0, r_den}) : w_t;
            r_lo  <= {r_lo[DW-2:0], w_ge};
        end
        if (i_cmd.res_load) begin
            r_res_r <= i_cmd.res_region;
            case (i_cmd.res_src)
                SRC_ZERO: r_res_v <= '0;
                SRC_PEN:  r_res_v <= r_pen;
                SRC_RDV:  r_res_v <= w_rv;
                SRC_INT:  r_res_v <= w_interp[DW-1:0];
                default:  r_res_v <= '0;
            endcase
        end
    end

    assign n_score = (r_res_r == REGION_WRITE) ? r_score
                   : ((r_clr ? '0 : r_score) + {{(SW-DW){r_res_v[DW-1]}}, r_res_v});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_score  <= '0;
        end else begin
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
                r_score  <= n_score;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            r_ovalue  <= r_res_v;
            r_oscore  <= n_score;
            r_oregion <= r_res_r;
        end
    end

    assign o_status.in_query = i_in_user[0] == FUNC_QUERY;
    assign o_status.q_lt     = r_q < w_rd;
    assign o_status.q_gt     = r_q > w_rd;
    assign o_status.q_eq     = r_q == w_rd;
    assign o_status.cnt_zero = r_count == '0;
    assign o_status.i_zero   = r_i == '0;
    assign o_status.den_le0  = w_rd >= r_dhi;
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {r_oscore, r_ovalue};
    assign o_out_user  = r_oregion;

endmodule

FILE: hdl/dti_controller.sv
module dti_controller import dti_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RDL  = 4'd2;
    localparam logic [3:0] S_SRCH = 4'd3;
    localparam logic [3:0] S_SCMP = 4'd4;
    localparam logic [3:0] S_RDI  = 4'd5;
    localparam logic [3:0] S_RDLO = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_INT  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_dcnt  = r_dcnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_query) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_ZERO;
                        n_state      = S_RD0;
                    end else begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = SRC_ZERO;
                        o_cmd.res_region = REGION_WRITE;
                        n_state          = S_FIN;
                    end
                end
            end
            S_RD0: begin
                if (i_status.q_lt) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_PEN;
                    o_cmd.res_region = REGION_BELOW;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                    n_state      = S_RDL;
                end
            end
            S_RDL: begin
                if (i_status.q_gt) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_RDV;
                    o_cmd.res_region = REGION_ABOVE;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.cnt_zero) begin
                    o_cmd.rd_sel = RD_HI;
                    n_state      = S_RDI;
                end else begin
                    o_cmd.rd_sel = RD_PROBE;
                    n_state      = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state        = S_SRCH;
            end
            S_RDI: begin
                o_cmd.lat_hi = 1'b1;
                if (i_status.q_eq || i_status.i_zero) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_RDV;
                    o_cmd.res_region = REGION_EXACT;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LO;
                    n_state      = S_RDLO;
                end
            end
            S_RDLO: begin
                if (i_status.den_le0) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_RDV;
                    o_cmd.res_region = REGION_INTERP;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.lat_lo = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_dcnt    = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_INT;
                end
            end
            S_INT: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_src    = SRC_INT;
                o_cmd.res_region = REGION_INTERP;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_dcnt  <= n_dcnt;
        end
    end

endmodule

FILE: hdl/distance_table_interpolator.sv
// A write loads its result without reading the table. A query checks the first entry
// (below the table), then the last one (above it), then runs a binary search that ends
// in an exact hit or in interpolation by a multiply and the 32-step restoring divider.
// Input is ready again in the cycle after a result loads; loads wait for a free output.
// Synchronous active-low reset clears control state and the score and presets the config
// registers; the table holds no reset value and must be written before it is queried.
`include "distance_table_interpolator_defines.svh"

module distance_table_interpolator import dti_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // entry_index, entry_distance, entry_value, query_distance
    input  logic [103:0]         i_s_axis_tdata,
    // func, clear_score
    input  logic [1:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // value, running_score
    output logic [95:0]          o_m_axis_tdata,
    // region
    output logic [2:0]           o_m_axis_tuser
);

    t_cmd    w_cmd;
    t_status w_status;

    dti_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dti_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

    `DTI_ASSERT_SAME(a_no_load_idle, i_clk, i_rst_n, o_s_axis_tready, !w_cmd.out_load)
    `DTI_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_cmd.out_load, o_m_axis_tvalid)
    `DTI_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule
